// File: design/pcf_pkg.sv
// pcf_pkg: request and result types, frame byte constants and step codes
// for the printer command framer; no dependencies
`default_nettype none

package pcf_pkg;

    typedef struct packed {
        logic [7:0] command;
        logic [7:0] header_length;
        logic [7:0] data_byte;
        logic       mirror_bits;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_last;
    } out_item_t;

    localparam logic [7:0] HDR_MAGIC0   = 8'h51;
    localparam logic [7:0] HDR_MAGIC1   = 8'h78;
    localparam logic [7:0] HDR_PAD      = 8'h00;
    localparam logic [7:0] TRAILER_BYTE = 8'hFF;
    localparam logic [7:0] CRC_POLY     = 8'h07;
    localparam logic [7:0] CRC_INIT     = 8'h00;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_MAGIC0  = 4'd0;
    localparam step_t STEP_MAGIC1  = 4'd1;
    localparam step_t STEP_CMD     = 4'd2;
    localparam step_t STEP_PAD0    = 4'd3;
    localparam step_t STEP_LEN     = 4'd4;
    localparam step_t STEP_PAD1    = 4'd5;
    localparam step_t STEP_DATA    = 4'd6;
    localparam step_t STEP_CRC     = 4'd7;
    localparam step_t STEP_TRAILER = 4'd8;

endpackage

`default_nettype wire

// File: design/printer_command_framer_crc8.sv
// printer_command_framer_crc8: an accepted request is held in the request stage; each
// byte it yields is registered in the output register; throughput one output byte per
// cycle while out_ready holds: a middle payload byte yields one output byte, a frame's
// first byte seven, its last byte three, a one-byte frame nine; reset clears the frame
// flag, crc and all valids; uses pcf_pkg and pcf_crc8
`default_nettype none

module printer_command_framer_crc8 (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire pcf_pkg::in_item_t    in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output pcf_pkg::out_item_t        out_item
);
    import pcf_pkg::*;

    logic      stage_valid_reg;
    in_item_t  stage_reg;
    step_t     pos_reg;
    logic      in_frame_reg;
    logic [7:0] crc_reg;
    logic      out_valid_reg;
    out_item_t out_reg;

    logic      first;
    step_t     step;
    logic      result_last;
    logic      out_free;
    logic      emit;
    logic      release_item;
    logic      load;
    logic [7:0] data_m;
    logic [7:0] crc_next;
    out_item_t result;

    assign first = !in_frame_reg;

    pcf_crc8 u_crc (
        .crc_in  (first ? CRC_INIT : crc_reg),
        .data_in (stage_reg.data_byte),
        .mirror  (stage_reg.mirror_bits),
        .data_out(data_m),
        .crc_out (crc_next)
    );

    assign step        = first ? pos_reg : step_t'(pos_reg + STEP_DATA);
    assign result_last = stage_reg.last_byte ? (step == STEP_TRAILER) : (step == STEP_DATA);

    always_comb
    begin
        result.frame_end = (step == STEP_TRAILER);
        result.run_last  = result_last;
        unique case (step)
            STEP_MAGIC0:  result.out_byte = HDR_MAGIC0;
            STEP_MAGIC1:  result.out_byte = HDR_MAGIC1;
            STEP_CMD:     result.out_byte = stage_reg.command;
            STEP_PAD0:    result.out_byte = HDR_PAD;
            STEP_LEN:     result.out_byte = stage_reg.header_length;
            STEP_PAD1:    result.out_byte = HDR_PAD;
            STEP_DATA:    result.out_byte = data_m;
            STEP_CRC:     result.out_byte = crc_next;
            STEP_TRAILER: result.out_byte = TRAILER_BYTE;
            default:      result.out_byte = HDR_PAD;
        endcase
    end

    assign out_free     = !out_valid_reg || out_ready;
    assign emit         = stage_valid_reg && out_free;
    assign release_item = emit && result_last;
    assign in_ready     = !stage_valid_reg || release_item;
    assign load         = in_valid && in_ready;

    // request stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            pos_reg         <= STEP_MAGIC0;
        end
        else if (load)
        begin
            stage_valid_reg <= 1'b1;
            pos_reg         <= STEP_MAGIC0;
        end
        else if (release_item)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            pos_reg <= step_t'(pos_reg + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= in_item;
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            crc_reg      <= CRC_INIT;
        end
        else if (release_item)
        begin
            in_frame_reg <= !stage_reg.last_byte;
            crc_reg      <= stage_reg.last_byte ? CRC_INIT : crc_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire

// File: design/pcf_crc8.sv
// pcf_crc8: optional bit reversal of one payload byte and a byte-wide
// crc-8 update (poly 0x07, msb first); uses pcf_pkg
`default_nettype none

module pcf_crc8 (
    input  wire logic [7:0] crc_in,
    input  wire logic [7:0] data_in,
    input  wire logic       mirror,
    output logic      [7:0] data_out,
    output logic      [7:0] crc_out
);
    import pcf_pkg::*;

    always_comb
    begin
        logic [7:0] rev;
        logic [7:0] c;
        for (int i = 0; i < 8; i++)
        begin
            rev[i] = data_in[7-i];
        end
        data_out = mirror ? rev : data_in;
        c = crc_in ^ data_out;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
// testbench for printer_command_framer_crc8: directed and random payload requests,
// a clocked driver and monitor, and a predictor of header, payload, crc and trailer
// bytes; depends on pcf_pkg and the framer rtl

module testbench;
    import pcf_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int IDLE_PCT       = 31;
    localparam int RANDOM_ITEMS   = 390;
    localparam int QUIET_FIRST    = 150;
    localparam int QUIET_LAST     = 230;
    localparam int HOLDOFF_AT     = 260;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_AT       = 330;
    localparam int TAIL_CYCLES    = 20;

    typedef struct {
        in_item_t item;
        bit       drain_first;
    } pending_request_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    pending_request_t pending_requests[$];
    out_item_t        expected_bytes[$];

    logic       framing_active = 1'b0;
    logic [7:0] running_crc = CRC_INIT;
    logic       in_taken = 1'b0;
    int         requests_taken = 0;
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         holdoff_left = 0;
    bit         holdoff_done = 1'b0;

    printer_command_framer_crc8 u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #1 clk = ~clk;

    function automatic logic [7:0] reverse_byte(logic [7:0] value);
        logic [7:0] flipped;
        for (int k = 0; k < 8; k++)
        begin
            flipped[k] = value[7 - k];
        end
        return flipped;
    endfunction

    function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] value);
        logic [7:0] acc;
        acc = crc ^ value;
        for (int k = 0; k < 8; k++)
        begin
            if (acc[7])
                acc = (acc << 1) ^ CRC_POLY;
            else
                acc = acc << 1;
        end
        return acc;
    endfunction

    task automatic predict_frame_bytes(in_item_t req);
        out_item_t  caused[$];
        logic [7:0] payload;
        if (!framing_active)
        begin
            caused.insert(caused.size(), '{HDR_MAGIC0, 1'b0, 1'b0});
            caused.insert(caused.size(), '{HDR_MAGIC1, 1'b0, 1'b0});
            caused.insert(caused.size(), '{req.command, 1'b0, 1'b0});
            caused.insert(caused.size(), '{HDR_PAD, 1'b0, 1'b0});
            caused.insert(caused.size(), '{req.header_length, 1'b0, 1'b0});
            caused.insert(caused.size(), '{HDR_PAD, 1'b0, 1'b0});
            running_crc    = CRC_INIT;
            framing_active = 1'b1;
        end
        payload = req.mirror_bits ? reverse_byte(req.data_byte) : req.data_byte;
        caused.insert(caused.size(), '{payload, 1'b0, 1'b0});
        running_crc = crc8_next(running_crc, payload);
        if (req.last_byte)
        begin
            caused.insert(caused.size(), '{running_crc, 1'b0, 1'b0});
            caused.insert(caused.size(), '{TRAILER_BYTE, 1'b1, 1'b0});
            framing_active = 1'b0;
            running_crc    = CRC_INIT;
        end
        caused[caused.size() - 1].run_last = 1'b1;
        foreach (caused[k])
            expected_bytes.insert(expected_bytes.size(), caused[k]);
    endtask

    task automatic add_request(logic [7:0] cmd, logic [7:0] len, logic [7:0] data,
                               logic mirror, logic last, bit drain);
        pending_request_t entry;
        entry.item.command       = cmd;
        entry.item.header_length = len;
        entry.item.data_byte     = data;
        entry.item.mirror_bits   = mirror;
        entry.item.last_byte     = last;
        entry.drain_first        = drain;
        pending_requests.insert(pending_requests.size(), entry);
    endtask

    function automatic bit quiet_phase();
        return requests_taken >= QUIET_FIRST && requests_taken < QUIET_LAST;
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_requests.size() != 0
                && (!pending_requests[0].drain_first || expected_bytes.size() == 0)
                && (quiet_phase() || $urandom_range(99) >= IDLE_PCT))
            begin
                in_item  <= pending_requests[0].item;
                in_valid <= 1'b1;
                void'(pending_requests.pop_front());
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (holdoff_left > 0)
        begin
            out_ready    <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end
        else if (!holdoff_done && requests_taken >= HOLDOFF_AT)
        begin
            out_ready    <= 1'b0;
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_done <= 1'b1;
        end
        else
            out_ready <= quiet_phase() || $urandom_range(99) >= IDLE_PCT;
    end

    // monitor
    always @(posedge clk)
    begin
        out_item_t want;
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            predict_frame_bytes(in_item);
            requests_taken <= requests_taken + 1;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected result: out_byte %02h", out_item.out_byte);
                mismatch_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_item.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %02h, actual %02h",
                           want.out_byte, out_item.out_byte);
                    mismatch_count++;
                end
                if (out_item.frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0b, actual %0b",
                           want.frame_end, out_item.frame_end);
                    mismatch_count++;
                end
                if (out_item.run_last !== want.run_last)
                begin
                    $error("run_last: expected %0b, actual %0b",
                           want.run_last, out_item.run_last);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL printer_command_framer_crc8");
            $finish;
        end
    end

    initial
    begin
        int queued;
        int frame_len;
        bit drain;
        logic [7:0] frame_hdr_len;

        // single-byte frames at the field extremes
        add_request(8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
        add_request(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0);
        // three-byte frame, header fields on later bytes ignored
        add_request(8'hA2, 8'h03, 8'h80, 1'b1, 1'b0, 1'b0);
        add_request(8'h5C, 8'hEE, 8'h01, 1'b0, 1'b0, 1'b0);
        add_request(8'h13, 8'h00, 8'h7F, 1'b1, 1'b1, 1'b0);
        // header length not matching the bytes given
        add_request(8'hBE, 8'h0A, 8'hC3, 1'b0, 1'b0, 1'b0);
        add_request(8'h00, 8'h01, 8'h3C, 1'b1, 1'b1, 1'b0);
        // alternating bit patterns, mirrored then straight
        add_request(8'hA1, 8'h06, 8'hAA, 1'b1, 1'b0, 1'b0);
        add_request(8'hA1, 8'h06, 8'h55, 1'b1, 1'b0, 1'b0);
        add_request(8'hA1, 8'h06, 8'hCC, 1'b1, 1'b0, 1'b0);
        add_request(8'hA1, 8'h06, 8'h33, 1'b1, 1'b0, 1'b0);
        add_request(8'hA1, 8'h06, 8'hF0, 1'b1, 1'b0, 1'b0);
        add_request(8'hA1, 8'h06, 8'h0F, 1'b1, 1'b1, 1'b0);
        add_request(8'h5E, 8'h06, 8'hAA, 1'b0, 1'b0, 1'b0);
        add_request(8'h5E, 8'h06, 8'h55, 1'b0, 1'b0, 1'b0);
        add_request(8'h5E, 8'h06, 8'hCC, 1'b0, 1'b0, 1'b0);
        add_request(8'h5E, 8'h06, 8'h33, 1'b0, 1'b0, 1'b0);
        add_request(8'h5E, 8'h06, 8'hF0, 1'b0, 1'b0, 1'b0);
        add_request(8'h5E, 8'h06, 8'h0F, 1'b0, 1'b1, 1'b0);

        queued = 0;
        while (queued < RANDOM_ITEMS)
        begin
            if ($urandom_range(9) == 0)
                frame_len = $urandom_range(40, 9);
            else
                frame_len = $urandom_range(6, 1);
            frame_hdr_len = ($urandom_range(3) == 0) ? 8'($urandom) : 8'(frame_len);
            drain = (queued < DRAIN_AT) && (queued + frame_len >= DRAIN_AT);
            for (int k = 0; k < frame_len; k++)
            begin
                add_request(k == 0 ? 8'($urandom) : 8'($urandom),
                            k == 0 ? frame_hdr_len : 8'($urandom),
                            8'($urandom), 1'($urandom), k == frame_len - 1,
                            drain && k == 0);
            end
            queued += frame_len;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || in_valid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_bytes.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_bytes.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("PASS printer_command_framer_crc8");
        else
            $display("FAIL printer_command_framer_crc8");
        $finish;
    end
endmodule
